[src/imh_pkg.sv]
// Shared types and constants for the indexed min-heap priority queue.
// Depends on nothing; imported by imh_ram2r, indexed_min_heap, imh_checker and tb.
`timescale 1ns / 1ps

package imh_pkg;

  // Width of the capacity limit register.
  localparam int unsigned CfgBits = 9;
  // Capacity limit after reset.
  localparam logic [CfgBits-1:0] CfgResetLimit = 9'd256;

  // Requested operation of one input transaction.
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_SET_KEY = 2'd1,
    OP_DEL_MIN = 2'd2,
    OP_REMOVE  = 2'd3
  } op_e;

  // Status codes of one result transaction.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_LOOK   = 10'b00_0000_0100,
    S_FETCH  = 10'b00_0000_1000,
    S_TAKE   = 10'b00_0001_0000,
    S_UP_RD  = 10'b00_0010_0000,
    S_UP_CMP = 10'b00_0100_0000,
    S_DN_RD  = 10'b00_1000_0000,
    S_DN_CMP = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

endpackage

[src/imh_ram2r.sv]
// Heap slot memory: one write port and two registered read ports.
// Depends on imh_pkg only through the common import style.
`timescale 1ns / 1ps

module imh_ram2r
  import imh_pkg::*;
#(
  parameter int unsigned WIDTH     = 72,
  parameter int unsigned ADDR_BITS = 9
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_a_i,
  input  logic [ADDR_BITS-1:0] raddr_b_i,
  output logic [WIDTH-1:0]     rdata_a_o,
  output logic [WIDTH-1:0]     rdata_b_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_BITS];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[src/indexed_min_heap.sv]
// Indexed binary min-heap priority queue, top level.
// Depends on imh_pkg and instantiates imh_ram2r for the heap slots.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request: insert, set
//   key, delete minimum or remove by id. Every request yields exactly one
//   result transaction on the output channel (out_valid_o / out_ready_i)
//   with a status and, for delete minimum and remove, the entry taken out.
//   One request is worked on at a time. A request that fails its checks
//   goes from the lookup straight to the result; a successful one walks
//   the heap one level at a time (one slot memory read, then compare and
//   write back). The walk sets the rate.
//   The result sits in an output register; the next request is taken while
//   it waits. If the receiver stalls, a finished result is held internally
//   until the output register drains, and no further request is taken.
//   After reset the id position table is cleared, one id per cycle, and
//   in_ready_o stays low meanwhile. Capacity limit writes (cfg_we_i) are
//   accepted at any time, also during that pass.

module indexed_min_heap
  import imh_pkg::*;
#(
  parameter int unsigned CAPACITY     = 256,
  parameter int unsigned ID_BITS      = 8,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CfgBits-1:0]             cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     operation_i,
  input  logic [ID_BITS-1:0]             item_id_i,
  input  logic signed [KEY_BITS-1:0]     key_i,
  input  logic [PAYLOAD_BITS-1:0]        payload_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     status_o,
  output logic [ID_BITS-1:0]             out_id_o,
  output logic signed [KEY_BITS-1:0]     out_key_o,
  output logic [PAYLOAD_BITS-1:0]        out_payload_o
);

  localparam int unsigned SlotBits = $clog2(CAPACITY + 1);
  localparam int unsigned EntryW   = ID_BITS + KEY_BITS + PAYLOAD_BITS;
  localparam int unsigned LimW     = (SlotBits > CfgBits) ? SlotBits : CfgBits;
  localparam int unsigned NumIds   = 2 ** ID_BITS;

  // Entry layout: {id, key, payload}.
  function automatic logic [ID_BITS-1:0] ent_id(input logic [EntryW-1:0] e);
    return e[EntryW-1 -: ID_BITS];
  endfunction

  function automatic logic [KEY_BITS-1:0] ent_key(input logic [EntryW-1:0] e);
    return e[PAYLOAD_BITS +: KEY_BITS];
  endfunction

  function automatic logic key_less(input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Registers.
  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic [ID_BITS-1:0]      id_q, id_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic [SlotBits-1:0]     pos_q, pos_d;
  logic [SlotBits-1:0]     cnt_q, cnt_d;
  logic [EntryW-1:0]       cur_q, cur_d;
  logic                    try_dn_q, try_dn_d;
  status_e                 res_st_q, res_st_d;
  logic [EntryW-1:0]       res_ent_q, res_ent_d;
  logic [ID_BITS-1:0]      clr_q;
  logic [CfgBits-1:0]      cap_q;
  logic                    out_valid_q;
  logic [2:0]              out_st_q;
  logic [EntryW-1:0]       out_ent_q;

  // Heap memory ports.
  logic                h_we;
  logic [SlotBits-1:0] h_waddr, h_ra, h_rb;
  logic [EntryW-1:0]   h_wdata, h_rda, h_rdb;

  // Position table: id to heap slot, zero meaning absent.
  logic [SlotBits-1:0] pos_mem_q [NumIds];
  logic                p_we;
  logic [ID_BITS-1:0]  p_waddr, p_raddr;
  logic [SlotBits-1:0] p_wdata, p_rdata_q;

  imh_ram2r #(
    .WIDTH     (EntryW),
    .ADDR_BITS (SlotBits)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (h_we),
    .waddr_i   (h_waddr),
    .wdata_i   (h_wdata),
    .raddr_a_i (h_ra),
    .raddr_b_i (h_rb),
    .rdata_a_o (h_rda),
    .rdata_b_o (h_rdb)
  );

  // Position table memory.
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pos_mem_q[p_waddr] <= p_wdata;
    end
    p_rdata_q <= pos_mem_q[p_raddr];
  end

  // Lookup and walk helpers.
  logic                found, full;
  logic [SlotBits:0]   lchild, rchild;
  logic [EntryW-1:0]   best_ent;
  logic                take_l, take_r;
  logic [KEY_BITS-1:0] best_key;

  assign found  = (p_rdata_q != '0) && (p_rdata_q <= cnt_q);
  assign full   = (LimW'(cnt_q) >= LimW'(cap_q)) || (cnt_q == SlotBits'(CAPACITY));
  assign lchild = {pos_q, 1'b0};
  assign rchild = {pos_q, 1'b1};

  // Smaller child that beats the moving entry; left wins ties.
  always_comb begin
    take_l   = key_less(ent_key(h_rda), ent_key(cur_q));
    best_key = take_l ? ent_key(h_rda) : ent_key(cur_q);
    take_r   = (rchild <= {1'b0, cnt_q}) && key_less(ent_key(h_rdb), best_key);
    best_ent = take_r ? h_rdb : h_rda;
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    id_d      = id_q;
    key_d     = key_q;
    pay_d     = pay_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    try_dn_d  = try_dn_q;
    res_st_d  = res_st_q;
    res_ent_d = res_ent_q;
    h_we      = 1'b0;
    h_waddr   = pos_q;
    h_wdata   = cur_q;
    h_ra      = '0;
    h_rb      = '0;
    p_we      = 1'b0;
    p_waddr   = ent_id(cur_q);
    p_wdata   = pos_q;
    p_raddr   = item_id_i;
    case (state_q)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = '0;
        if (clr_q == ID_BITS'(NumIds - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        h_ra = SlotBits'(1);
        if (in_valid_i) begin
          op_d      = op_e'(operation_i);
          id_d      = item_id_i;
          key_d     = key_i;
          pay_d     = payload_i;
          res_st_d  = ST_OK;
          res_ent_d = '0;
          state_d   = S_LOOK;
        end
      end
      S_LOOK: begin
        case (op_q)
          OP_INSERT: begin
            if (full) begin
              res_st_d = ST_FULL;
              state_d  = S_DONE;
            end else if (found) begin
              res_st_d = ST_DUPLICATE;
              state_d  = S_DONE;
            end else begin
              cnt_d    = cnt_q + 1'b1;
              pos_d    = cnt_q + 1'b1;
              cur_d    = {id_q, key_q, pay_q};
              try_dn_d = 1'b0;
              state_d  = S_UP_RD;
            end
          end
          OP_DEL_MIN: begin
            if (cnt_q == '0) begin
              res_st_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              res_ent_d = h_rda;
              pos_d     = SlotBits'(1);
              p_we      = 1'b1;
              p_waddr   = ent_id(h_rda);
              p_wdata   = '0;
              cnt_d     = cnt_q - 1'b1;
              h_ra      = cnt_q;
              state_d   = (cnt_q == SlotBits'(1)) ? S_DONE : S_TAKE;
            end
          end
          default: begin
            // Set key and remove both need the entry at the id's slot.
            if (!found) begin
              res_st_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end else begin
              pos_d   = p_rdata_q;
              h_ra    = p_rdata_q;
              state_d = S_FETCH;
            end
          end
        endcase
      end
      S_FETCH: begin
        if (op_q == OP_SET_KEY) begin
          cur_d    = {id_q, key_q, h_rda[PAYLOAD_BITS-1:0]};
          try_dn_d = 1'b0;
          if (key_less(ent_key(h_rda), key_q)) begin
            state_d = S_DN_RD;
          end else if (key_less(key_q, ent_key(h_rda))) begin
            state_d = S_UP_RD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          res_ent_d = h_rda;
          p_we      = 1'b1;
          p_waddr   = ent_id(h_rda);
          p_wdata   = '0;
          cnt_d     = cnt_q - 1'b1;
          h_ra      = cnt_q;
          state_d   = (pos_q == cnt_q) ? S_DONE : S_TAKE;
        end
      end
      S_TAKE: begin
        // Last entry fills the hole; it may go either way.
        cur_d    = h_rda;
        try_dn_d = 1'b1;
        state_d  = S_UP_RD;
      end
      S_UP_RD: begin
        if (pos_q == SlotBits'(1)) begin
          if (try_dn_q) begin
            state_d = S_DN_RD;
          end else begin
            h_we    = 1'b1;
            p_we    = 1'b1;
            state_d = S_DONE;
          end
        end else begin
          h_ra    = pos_q >> 1;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (key_less(ent_key(cur_q), ent_key(h_rda))) begin
          // Parent moves down into the hole.
          h_we     = 1'b1;
          h_wdata  = h_rda;
          p_we     = 1'b1;
          p_waddr  = ent_id(h_rda);
          pos_d    = pos_q >> 1;
          try_dn_d = 1'b0;
          state_d  = S_UP_RD;
        end else if (try_dn_q) begin
          state_d = S_DN_RD;
        end else begin
          h_we    = 1'b1;
          p_we    = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DN_RD: begin
        if (lchild > {1'b0, cnt_q}) begin
          h_we    = 1'b1;
          p_we    = 1'b1;
          state_d = S_DONE;
        end else begin
          h_ra    = lchild[SlotBits-1:0];
          h_rb    = rchild[SlotBits-1:0];
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (take_l || take_r) begin
          // Smaller child moves up into the hole.
          h_we    = 1'b1;
          h_wdata = best_ent;
          p_we    = 1'b1;
          p_waddr = ent_id(best_ent);
          pos_d   = take_r ? rchild[SlotBits-1:0] : lchild[SlotBits-1:0];
          state_d = S_DN_RD;
        end else begin
          h_we    = 1'b1;
          p_we    = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      cap_q       <= CfgResetLimit;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and walk registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    key_q     <= key_d;
    pay_q     <= pay_d;
    pos_q     <= pos_d;
    cur_q     <= cur_d;
    try_dn_q  <= try_dn_d;
    res_st_q  <= res_st_d;
    res_ent_q <= res_ent_d;
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_st_q  <= res_st_q;
      out_ent_q <= res_ent_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign out_id_o      = ent_id(out_ent_q);
  assign out_key_o     = ent_key(out_ent_q);
  assign out_payload_o = out_ent_q[PAYLOAD_BITS-1:0];

  // The entry count never passes the heap size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SlotBits'(CAPACITY))
    else $error("entry count above capacity");

  // An accepted transaction is looked up in the next cycle.
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_LOOK))
    else $error("accepted transaction not looked up");

  // A finished result reaches the output register when it is free.
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || out_ready_i)) |=> out_valid_o)
    else $error("result not presented");

  // Count changes only while a request is being worked on.
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |=> $stable(cnt_q))
    else $error("entry count changed while idle");

endmodule

[test/imh_checker.sv]
// Checker for the indexed min-heap: watches both channels, predicts results, compares.
// Depends on imh_pkg; instantiated by tb beside the block under test.
`timescale 1ns / 1ps

module imh_checker
  import imh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgBits-1:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          item_id_i,
  input  logic signed [31:0]  key_i,
  input  logic [31:0]         payload_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [2:0]          status_i,
  input  logic [7:0]          out_id_i,
  input  logic signed [31:0]  out_key_i,
  input  logic [31:0]         out_payload_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         id;
    logic signed [31:0] key;
    logic [31:0]        payload;
  } heap_result_t;

  // Shadow copy of the heap, 1-based.
  logic signed [31:0] shadow_key [1:256];
  logic [7:0]         shadow_id [1:256];
  logic [31:0]        shadow_pay [1:256];
  int unsigned        shadow_slot [0:255];
  int unsigned        shadow_count;
  int unsigned        shadow_limit;
  heap_result_t       result_queue[$];

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [31:0] k;
    logic [7:0] i;
    logic [31:0] p;
    k = shadow_key[a]; i = shadow_id[a]; p = shadow_pay[a];
    shadow_key[a] = shadow_key[b]; shadow_id[a] = shadow_id[b];
    shadow_pay[a] = shadow_pay[b];
    shadow_key[b] = k; shadow_id[b] = i; shadow_pay[b] = p;
    shadow_slot[shadow_id[a]] = a;
    shadow_slot[shadow_id[b]] = b;
  endfunction

  function automatic void sift_up(int unsigned pos);
    while (pos > 1 && shadow_key[pos] < shadow_key[pos/2]) begin
      swap_entries(pos, pos/2);
      pos = pos / 2;
    end
  endfunction

  function automatic void sift_down(int unsigned pos);
    int unsigned best;
    while (2*pos <= shadow_count) begin
      best = pos;
      if (shadow_key[2*pos] < shadow_key[best]) best = 2*pos;
      if (2*pos+1 <= shadow_count && shadow_key[2*pos+1] < shadow_key[best]) begin
        best = 2*pos+1;
      end
      if (best == pos) break;
      swap_entries(pos, best);
      pos = best;
    end
  endfunction

  // Removes the entry at pos and refills the hole with the last entry.
  function automatic void take_entry(int unsigned pos);
    int unsigned last;
    last = shadow_count;
    shadow_slot[shadow_id[pos]] = 0;
    shadow_count--;
    if (pos != last) begin
      shadow_key[pos] = shadow_key[last];
      shadow_id[pos] = shadow_id[last];
      shadow_pay[pos] = shadow_pay[last];
      shadow_slot[shadow_id[pos]] = pos;
      if (pos > 1 && shadow_key[pos] < shadow_key[pos/2]) sift_up(pos);
      else sift_down(pos);
    end
  endfunction

  function automatic int unsigned lookup_slot(logic [7:0] id);
    int unsigned s;
    s = shadow_slot[id];
    if (s == 0 || s > shadow_count) return 0;
    return s;
  endfunction

  function automatic heap_result_t heap_outcome(op_e op, logic [7:0] id,
                                                logic signed [31:0] key,
                                                logic [31:0] pay);
    heap_result_t r;
    int unsigned pos;
    logic signed [31:0] old_key;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= shadow_limit) r.status = ST_FULL;
        else if (lookup_slot(id) != 0) r.status = ST_DUPLICATE;
        else begin
          shadow_count++;
          shadow_key[shadow_count] = key;
          shadow_id[shadow_count] = id;
          shadow_pay[shadow_count] = pay;
          shadow_slot[id] = shadow_count;
          sift_up(shadow_count);
        end
      end
      OP_SET_KEY: begin
        pos = lookup_slot(id);
        if (pos == 0) r.status = ST_NOT_FOUND;
        else begin
          old_key = shadow_key[pos];
          shadow_key[pos] = key;
          if (old_key < key) sift_down(pos);
          else if (key < old_key) sift_up(pos);
        end
      end
      OP_DEL_MIN: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else begin
          r.id = shadow_id[1]; r.key = shadow_key[1]; r.payload = shadow_pay[1];
          take_entry(1);
        end
      end
      default: begin
        pos = lookup_slot(id);
        if (pos == 0) r.status = ST_NOT_FOUND;
        else begin
          r.id = shadow_id[pos]; r.key = shadow_key[pos]; r.payload = shadow_pay[pos];
          take_entry(pos);
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  // Predict on each input transaction, compare on each output transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      shadow_count = 0;
      shadow_limit = 256;
      for (int i = 0; i < 256; i++) shadow_slot[i] = 0;
      result_queue.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_queue.size() == 0) begin
          report_mismatch("unexpected result", 32'(status_i), 32'd0);
        end else begin
          want = result_queue.pop_front();
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (out_id_i !== want.id) report_mismatch("out_id", out_id_i, want.id);
          if (out_key_i !== want.key) report_mismatch("out_key", out_key_i, want.key);
          if (out_payload_i !== want.payload) begin
            report_mismatch("out_payload", out_payload_i, want.payload);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        result_queue.push_back(heap_outcome(op_e'(operation_i), item_id_i, key_i,
                                            payload_i));
      end
      if (cfg_we_i) shadow_limit = (cfg_wdata_i > 256) ? 256 : cfg_wdata_i;
      pending_o = result_queue.size();
    end
  end

endmodule

[test/tb.sv]
// Testbench top for indexed_min_heap: clock, reset, stimulus and verdict.
// Depends on imh_pkg, indexed_min_heap and imh_checker.
`timescale 1ns / 1ps

module tb
  import imh_pkg::*;
();

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgBits-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = '0;
  logic [7:0]         item_id_i = '0;
  logic signed [31:0] key_i = '0;
  logic [31:0]        payload_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         status_o;
  logic [7:0]         out_id_o;
  logic signed [31:0] out_key_o;
  logic [31:0]        out_payload_o;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  bit                 long_stall_req = 1'b0;
  bit                 stim_done = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  indexed_min_heap u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .operation_i, .item_id_i, .key_i, .payload_i, .out_valid_o, .out_ready_i,
    .status_o, .out_id_o, .out_key_o, .out_payload_o
  );

  imh_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_i(in_ready_o),
    .operation_i, .item_id_i, .key_i, .payload_i, .out_valid_i(out_valid_o),
    .out_ready_i, .status_i(status_o), .out_id_i(out_id_o), .out_key_i(out_key_o),
    .out_payload_i(out_payload_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  always begin
    int unsigned n;
    @(posedge clk_i);
    if (long_stall_req) begin
      out_ready_i <= 1'b0;
      repeat (300) @(posedge clk_i);
      long_stall_req = 1'b0;
    end
    n = gap_length();
    if (n != 0 && !stim_done) begin
      out_ready_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  // Valid stays high from one transaction to the next unless a gap is taken.
  task automatic send_op(op_e op, logic [7:0] id, logic signed [31:0] key,
                         logic [31:0] pay, bit gaps);
    int unsigned n;
    n = gaps ? gap_length() : 0;
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    item_id_i <= id;
    key_i <= key;
    payload_i <= pay;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CfgBits-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random mix, biased toward a small id pool so hits and collisions are common.
  task automatic random_ops(int count, int id_pool);
    op_e op;
    logic [7:0] id;
    logic signed [31:0] key;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = OP_INSERT;
        4, 5: op = OP_SET_KEY;
        6, 7: op = OP_DEL_MIN;
        default: op = OP_REMOVE;
      endcase
      id = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, id_pool - 1));
      key = $urandom_range(0, 1) ? 32'($urandom_range(0, 15)) - 8 : 32'($urandom);
      send_op(op, id, key, $urandom, 1'b1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty cases, extremes, ties, same key, last-slot removal.
    send_op(OP_DEL_MIN, 8'd0, 32'sd0, 32'd0, 1'b0);
    send_op(OP_REMOVE, 8'd5, 32'sd0, 32'd0, 1'b0);
    send_op(OP_SET_KEY, 8'd5, 32'sd0, 32'd0, 1'b0);
    send_op(OP_INSERT, 8'd255, 32'h7fffffff, 32'hffffffff, 1'b0);
    send_op(OP_INSERT, 8'd0, 32'h80000000, 32'h00000000, 1'b0);
    send_op(OP_INSERT, 8'd0, 32'sd1, 32'd1, 1'b0);
    send_op(OP_INSERT, 8'd7, 32'sd3, 32'haaaa5555, 1'b0);
    send_op(OP_INSERT, 8'd8, 32'sd3, 32'h5555aaaa, 1'b0);
    send_op(OP_SET_KEY, 8'd7, 32'sd3, 32'd0, 1'b0);
    send_op(OP_SET_KEY, 8'd255, -32'sd5, 32'd0, 1'b0);
    send_op(OP_SET_KEY, 8'd0, 32'sd100, 32'd0, 1'b0);
    send_op(OP_REMOVE, 8'd8, 32'sd0, 32'd0, 1'b0);
    send_op(OP_REMOVE, 8'd7, 32'sd0, 32'd0, 1'b0);
    send_op(OP_DEL_MIN, 8'd0, 32'sd0, 32'd0, 1'b0);
    send_op(OP_DEL_MIN, 8'd0, 32'sd0, 32'd0, 1'b0);
    send_op(OP_DEL_MIN, 8'd0, 32'sd0, 32'd0, 1'b0);
    drain_all();

    // Zero limit: every insert reports full, even a duplicate-free one.
    write_limit(9'd0);
    send_op(OP_INSERT, 8'd1, 32'sd1, 32'd1, 1'b0);
    drain_all();

    // Small limit with long receiver hold-off so the block backs up.
    write_limit(9'd3);
    long_stall_req = 1'b1;
    random_ops(60, 8);
    drain_all();

    // Above-capacity value acts as the full capacity.
    write_limit(9'd511);
    random_ops(150, 40);
    drain_all();

    write_limit(9'd1);
    random_ops(30, 4);
    drain_all();

    write_limit(9'd256);
    random_ops(180, 255);
    drain_all();
    stim_done = 1'b1;
    repeat (40) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[indexed_min_heap.f]
src/imh_pkg.sv
src/imh_ram2r.sv
src/indexed_min_heap.sv
test/imh_checker.sv
test/tb.sv
